FILE: rtl/event_record_deframer_unit_macros.svh
// assertion macros shared by the event record deframer checkers
`ifndef EVENT_RECORD_DEFRAMER_UNIT_MACROS_SVH
`define EVENT_RECORD_DEFRAMER_UNIT_MACROS_SVH

// same-cycle implication, disabled while in reset
`define ERD_ASSERT_SAME(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// next-cycle implication, disabled while in reset
`define ERD_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: rtl/erd_pkg.sv
// types, constants and the crc step of the event record deframer
`default_nettype none

package erd_pkg;

	localparam int FULL_RECORD_BYTES    = 16;
	localparam int COMPACT_RECORD_BYTES = 9;
	localparam int PAYLOAD_DEPTH        = 14;
	localparam int LEN_W                = 5;
	localparam int CNT_W                = 4;
	localparam int IDX_W                = $clog2(PAYLOAD_DEPTH);

	localparam logic [15:0] CRC_INIT      = 16'hFFFF;
	localparam logic [15:0] CRC_POLY      = 16'h1021;
	localparam logic [15:0] BEARING_LIMIT = 16'd3600;

	localparam logic [2:0] STATUS_OK      = 3'd0;
	localparam logic [2:0] STATUS_CRC     = 3'd1;
	localparam logic [2:0] STATUS_BEARING = 3'd2;
	localparam logic [2:0] STATUS_TIER    = 3'd3;
	localparam logic [2:0] STATUS_CLASS   = 3'd4;

	localparam int          PADDR_W     = 4;
	localparam logic [1:0] REG_COMPACT  = 2'd0;
	localparam logic [1:0] REG_TIER_LIM = 2'd1;
	localparam logic [1:0] REG_CLASS_LIM = 2'd2;

	typedef logic [PAYLOAD_DEPTH-1:0][7:0] payload_t;

	typedef struct packed {
		logic        compact;
		logic        crc_ok;
		logic [15:0] wire_checksum;
		payload_t    payload;
	} rec_entry_t;

	function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] data);
		logic [15:0] c;
		c = crc ^ {data, 8'h00};
		for (int k = 0; k < 8; k++) begin
			if (c[15]) begin
				c = {c[14:0], 1'b0} ^ CRC_POLY;
			end else begin
				c = {c[14:0], 1'b0};
			end
		end
		return c;
	endfunction

endpackage

`default_nettype wire

FILE: rtl/erd_stream_if.sv
// valid/ready channels for record bytes and decoded records
`default_nettype none

interface erd_in_if;
	logic       valid;
	logic       ready;
	logic [7:0] wire_byte;
	logic       frame_start;

	modport source (output valid, output wire_byte, output frame_start, input ready);
	modport sink (input valid, input wire_byte, input frame_start, output ready);
endinterface

interface erd_out_if;
	logic        valid;
	logic        ready;
	logic [31:0] time_deciseconds;
	logic [15:0] node_id;
	logic [15:0] bearing_tenths;
	logic [7:0]  bearing_spread;
	logic [7:0]  tier;
	logic [7:0]  event_class;
	logic [7:0]  confidence;
	logic [15:0] sequence_res;
	logic [15:0] wire_checksum;
	logic [2:0]  status;

	modport source (
		output valid, output time_deciseconds, output node_id, output bearing_tenths,
		output bearing_spread, output tier, output event_class, output confidence,
		output sequence_res, output wire_checksum, output status, input ready
	);
	modport sink (
		input valid, input time_deciseconds, input node_id, input bearing_tenths,
		input bearing_spread, input tier, input event_class, input confidence,
		input sequence_res, input wire_checksum, input status, output ready
	);
endinterface

`default_nettype wire

FILE: rtl/event_record_deframer_unit.sv
// top level of the event record deframer: register port, front, record queue and back
// Takes one record byte per cycle with no gaps between records. The front counts
// bytes and folds each payload byte into a CRC-16/CCITT-FALSE with a byte-wide step;
// on the last byte of a record it pushes the payload, checksum and crc verdict into
// a queue of QUEUE_DEPTH records. The back decodes one record a cycle into its output
// register unless the output is held back. Byte beats stall only while the queue is
// full, which takes results held back on the output channel. Registers are to be
// written over the APB port while no record is in flight, which the block does not
// enforce; a layout change applies from the next byte on.
`default_nettype none

module event_record_deframer_unit #(
	parameter int QUEUE_DEPTH = 2
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	erd_in_if.sink                            wire_bytes,
	erd_out_if.source                         records,
	input  wire logic                         psel,
	input  wire logic                         penable,
	input  wire logic                         pwrite,
	input  wire logic [erd_pkg::PADDR_W-1:0] paddr,
	input  wire logic [31:0]                  pwdata,
	output      logic [31:0]                  prdata,
	output      logic                         pready
);

	logic       compact_q;
	logic [7:0] tier_limit_q;
	logic [7:0] class_limit_q;
	logic       wr_en;

	logic                q_push;
	logic                q_pop;
	logic                q_full;
	logic                q_empty;
	erd_pkg::rec_entry_t q_in;
	erd_pkg::rec_entry_t q_head;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			compact_q     <= 1'b0;
			tier_limit_q  <= 8'd3;
			class_limit_q <= 8'd3;
		end else if (wr_en) begin
			unique case (paddr[3:2])
				erd_pkg::REG_COMPACT:   compact_q     <= pwdata[0];
				erd_pkg::REG_TIER_LIM:  tier_limit_q  <= pwdata[7:0];
				erd_pkg::REG_CLASS_LIM: class_limit_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	always_comb begin
		unique case (paddr[3:2])
			erd_pkg::REG_COMPACT:   prdata = {31'h0, compact_q};
			erd_pkg::REG_TIER_LIM:  prdata = {24'h0, tier_limit_q};
			erd_pkg::REG_CLASS_LIM: prdata = {24'h0, class_limit_q};
			default:                prdata = '0;
		endcase
	end

	erd_front u_front (
		.clk     (clk),
		.arst_n  (arst_n),
		.bytes   (wire_bytes),
		.compact (compact_q),
		.q_full  (q_full),
		.q_push  (q_push),
		.q_entry (q_in)
	);

	erd_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (q_push),
		.push_entry (q_in),
		.full       (q_full),
		.pop        (q_pop),
		.head       (q_head),
		.empty      (q_empty)
	);

	erd_back u_back (
		.clk         (clk),
		.arst_n      (arst_n),
		.head        (q_head),
		.empty       (q_empty),
		.pop         (q_pop),
		.tier_limit  (tier_limit_q),
		.class_limit (class_limit_q),
		.records     (records)
	);

endmodule

`default_nettype wire

FILE: rtl/erd_front.sv
// byte counter, running crc and payload capture; hands finished records to the queue
`default_nettype none

module erd_front (
	input  wire logic                clk,
	input  wire logic                arst_n,
	erd_in_if.sink                   bytes,
	input  wire logic                compact,
	input  wire logic                q_full,
	output      logic                q_push,
	output      erd_pkg::rec_entry_t q_entry
);

	logic [erd_pkg::CNT_W-1:0]  cnt_q;
	logic [15:0]                crc_q;
	logic [7:0]                 low_q;
	erd_pkg::payload_t          payload_q;

	logic [erd_pkg::LEN_W-1:0]  rec_len;
	logic                       restart;
	logic [erd_pkg::CNT_W-1:0]  pos;
	logic [erd_pkg::LEN_W-1:0]  pos_x;
	logic [15:0]                crc_cur;
	logic                       in_payload;
	logic                       in_low;
	logic                       beat;

	assign bytes.ready = !q_full;
	assign beat        = bytes.valid && bytes.ready;

	assign rec_len    = compact ? erd_pkg::LEN_W'(erd_pkg::COMPACT_RECORD_BYTES)
	                            : erd_pkg::LEN_W'(erd_pkg::FULL_RECORD_BYTES);
	assign restart    = bytes.frame_start || ({1'b0, cnt_q} >= rec_len);
	assign pos        = restart ? '0 : cnt_q;
	assign pos_x      = {1'b0, pos};
	assign crc_cur    = restart ? erd_pkg::CRC_INIT : crc_q;
	assign in_payload = pos_x < (rec_len - erd_pkg::LEN_W'(2));
	assign in_low     = pos_x == (rec_len - erd_pkg::LEN_W'(2));

	assign q_push                = beat && !in_payload && !in_low;
	assign q_entry.compact       = compact;
	assign q_entry.wire_checksum = {bytes.wire_byte, low_q};
	assign q_entry.crc_ok        = crc_cur == {bytes.wire_byte, low_q};
	assign q_entry.payload       = payload_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q <= '0;
			crc_q <= erd_pkg::CRC_INIT;
		end else if (beat) begin
			if (in_payload) begin
				crc_q <= erd_pkg::crc_byte(crc_cur, bytes.wire_byte);
				cnt_q <= pos + erd_pkg::CNT_W'(1);
			end else if (in_low) begin
				crc_q <= crc_cur;
				cnt_q <= pos + erd_pkg::CNT_W'(1);
			end else begin
				crc_q <= erd_pkg::CRC_INIT;
				cnt_q <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (beat && in_payload) begin
			payload_q[pos[erd_pkg::IDX_W-1:0]] <= bytes.wire_byte;
		end
		if (beat && in_low) begin
			low_q <= bytes.wire_byte;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/erd_queue.sv
// short fifo of finished records between front and back
`default_nettype none

module erd_queue #(
	parameter int DEPTH = 2
) (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire logic                push,
	input  wire erd_pkg::rec_entry_t push_entry,
	output      logic                full,
	input  wire logic                pop,
	output      erd_pkg::rec_entry_t head,
	output      logic                empty
);

	localparam int PTR_W = $clog2(DEPTH);
	localparam int FILL_W = $clog2(DEPTH + 1);

	erd_pkg::rec_entry_t mem [DEPTH];
	logic [PTR_W-1:0]    wr_ptr_q;
	logic [PTR_W-1:0]    rd_ptr_q;
	logic [FILL_W-1:0]   fill_q;

	assign full  = fill_q == FILL_W'(DEPTH);
	assign empty = fill_q == '0;
	assign head  = mem[rd_ptr_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			fill_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_q + PTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_q + PTR_W'(1);
			end
			if (push && !pop) begin
				fill_q <= fill_q + FILL_W'(1);
			end else if (pop && !push) begin
				fill_q <= fill_q - FILL_W'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem[wr_ptr_q] <= push_entry;
		end
	end

endmodule

`default_nettype wire

FILE: rtl/erd_back.sv
// field decode, checks and output register
`default_nettype none

module erd_back (
	input  wire logic                clk,
	input  wire logic                arst_n,
	input  wire erd_pkg::rec_entry_t head,
	input  wire logic                empty,
	output      logic                pop,
	input  wire logic [7:0]          tier_limit,
	input  wire logic [7:0]          class_limit,
	erd_out_if.source                records
);

	logic        valid_q;
	logic [31:0] time_q;
	logic [15:0] node_q;
	logic [15:0] bearing_q;
	logic [7:0]  spread_q;
	logic [7:0]  tier_q;
	logic [7:0]  class_q;
	logic [7:0]  conf_q;
	logic [15:0] seq_q;
	logic [15:0] wire_q;
	logic [2:0]  status_q;

	erd_pkg::payload_t p;
	logic [31:0] t_d;
	logic [15:0] node_d;
	logic [15:0] bear_d;
	logic [7:0]  spread_d;
	logic [7:0]  tier_d;
	logic [7:0]  class_d;
	logic [7:0]  conf_d;
	logic [15:0] seq_d;
	logic [2:0]  status_d;

	assign p   = head.payload;
	assign pop = !empty && (!valid_q || records.ready);

	always_comb begin
		if (head.compact) begin
			t_d      = '0;
			node_d   = {p[1], p[0]};
			bear_d   = {4'h0, p[3][3:0], p[2]};
			spread_d = {4'h0, p[3][7:4]};
			tier_d   = {6'h00, p[4][3:2]};
			class_d  = {6'h00, p[4][1:0]};
			conf_d   = {p[5][1:0], p[4][7:4], 2'b00};
			seq_d    = {8'h00, p[6]};
		end else begin
			t_d      = {p[3], p[2], p[1], p[0]};
			node_d   = {p[5], p[4]};
			bear_d   = {p[7], p[6]};
			tier_d   = p[8];
			class_d  = p[9];
			conf_d   = p[10];
			spread_d = p[11];
			seq_d    = {p[13], p[12]};
		end
		if (!head.crc_ok) begin
			status_d = erd_pkg::STATUS_CRC;
		end else if (bear_d >= erd_pkg::BEARING_LIMIT) begin
			status_d = erd_pkg::STATUS_BEARING;
		end else if (tier_d > tier_limit) begin
			status_d = erd_pkg::STATUS_TIER;
		end else if (class_d > class_limit) begin
			status_d = erd_pkg::STATUS_CLASS;
		end else begin
			status_d = erd_pkg::STATUS_OK;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (pop) begin
			valid_q <= 1'b1;
		end else if (records.ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (pop) begin
			time_q    <= t_d;
			node_q    <= node_d;
			bearing_q <= bear_d;
			spread_q  <= spread_d;
			tier_q    <= tier_d;
			class_q   <= class_d;
			conf_q    <= conf_d;
			seq_q     <= seq_d;
			wire_q    <= head.wire_checksum;
			status_q  <= status_d;
		end
	end

	assign records.valid            = valid_q;
	assign records.time_deciseconds = time_q;
	assign records.node_id          = node_q;
	assign records.bearing_tenths   = bearing_q;
	assign records.bearing_spread   = spread_q;
	assign records.tier             = tier_q;
	assign records.event_class      = class_q;
	assign records.confidence       = conf_q;
	assign records.sequence_res     = seq_q;
	assign records.wire_checksum    = wire_q;
	assign records.status           = status_q;

endmodule

`default_nettype wire

FILE: rtl/erd_checker.sv
// port-level checks of the event record deframer and their bind
`default_nettype none

`include "event_record_deframer_unit_macros.svh"

module erd_checker (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        out_valid,
	input wire logic        out_ready,
	input wire logic [15:0] bearing_tenths,
	input wire logic [15:0] wire_checksum,
	input wire logic [2:0]  status
);

	`ERD_ASSERT_NEXT(a_result_holds, out_valid && !out_ready, out_valid && $stable(status) && $stable(wire_checksum) && $stable(bearing_tenths), "stalled result changed")
	`ERD_ASSERT_SAME(a_status_code, out_valid, status <= erd_pkg::STATUS_CLASS, "status code out of range")
	`ERD_ASSERT_SAME(a_ok_bearing, out_valid && (status == erd_pkg::STATUS_OK), bearing_tenths < erd_pkg::BEARING_LIMIT, "ok result with bearing out of range")

endmodule

bind event_record_deframer_unit erd_checker u_erd_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.out_valid      (records.valid),
	.out_ready      (records.ready),
	.bearing_tenths (records.bearing_tenths),
	.wire_checksum  (records.wire_checksum),
	.status         (records.status)
);

`default_nettype wire
